[design/sis_pkg.sv]
// shared types, constants and arithmetic helpers for the icon pixel shader
`default_nettype none
package sis_pkg;

  localparam int unsigned GridSize = 32;
  localparam int unsigned NumStages = 16;

  localparam logic [23:0] AccentReset = 24'h00D4FF;
  localparam logic [23:0] BodyReset = 24'h1A1A2E;

  localparam logic CfgAccent = 1'b0;
  localparam logic CfgBody = 1'b1;

  localparam logic [16:0] OneQ15 = 17'd32768;
  localparam logic [12:0] GlowInQ8 = 13'd2739;
  localparam logic [12:0] GlowOutQ8 = 13'd3917;
  localparam logic [24:0] GlowSpanHalf = 25'd589;
  localparam logic [25:0] GlowRecip = 26'(64'd34359738368 / 64'd589);
  localparam logic [14:0] GlowPeakQ15 = 15'd19661;
  localparam logic [13:0] HexKQ14 = 14'd14189;
  localparam logic signed [25:0] BodyEdge = 26'sd409600;
  localparam logic signed [25:0] RingMid = 26'sd327680;
  localparam logic signed [25:0] DiamondEdge = 26'sd147456;
  localparam logic signed [25:0] OneQ15S = 26'sd32768;

  localparam int SqrtTopBit = 24;

  typedef struct packed {
    logic [24:0] n;
    logic [25:0] root;
  } sq_t;

  typedef struct packed {
    logic [15:0] a;
    logic [22:0] r;
    logic [22:0] g;
    logic [22:0] b;
  } acc_t;

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [25:0] bt;
    logic [25:0] t;
    sq_t o;
    bt = 26'd1 << (SqrtTopBit - 2 * k);
    t = s.root + bt;
    o = s;
    if ({1'b0, s.n} >= t) begin
      o.n = s.n - t[24:0];
      o.root = (s.root >> 1) + bt;
    end else begin
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic logic [15:0] clamp_q15(logic signed [25:0] v);
    logic [15:0] r;
    if (v < 26'sd0) begin
      r = 16'd0;
    end else if (v > OneQ15S) begin
      r = 16'd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_q15(logic [16:0] v);
    logic [15:0] r;
    if (v > OneQ15) begin
      r = 16'd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [22:0] mix_ch(logic [7:0] c, logic [15:0] sa,
                                         logic [15:0] inv, logic [22:0] acc);
    logic [38:0] p;
    p = 39'(acc) * 39'(inv);
    return 23'(23'(c) * 23'(sa)) + 23'(p >> 15);
  endfunction

  // source-over of one layer onto the premultiplied accumulator
  function automatic acc_t blend(acc_t a, logic [23:0] col, logic [15:0] sa);
    logic [15:0] inv;
    logic [31:0] pa;
    acc_t o;
    inv = 16'(OneQ15 - 17'(sa));
    pa = 32'(a.a) * 32'(inv);
    o.a = 16'(17'(sa) + 17'(pa >> 15));
    o.r = mix_ch(col[23:16], sa, inv, a.r);
    o.g = mix_ch(col[15:8], sa, inv, a.g);
    o.b = mix_ch(col[7:0], sa, inv, a.b);
    return o;
  endfunction

endpackage
`default_nettype wire

[design/sdf_icon_pixel_shader_top.sv]
// top level of the icon pixel shader: sixteen-stage pixel pipeline
`default_nettype none
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: pixel word
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: alpha and rgb bytes
// cfg       in   cfg_we_i                         cfg_idx_i, cfg_data_i
//
// one word per clock while the output is not stalled
// the deepest path is the glow path: 13-digit square root, reciprocal divide,
// three multiplies and four blend stages
// reset clears the valid bits and loads the default colors
// a stall freezes every stage at once; the output register holds its word
module sdf_icon_pixel_shader_top import sis_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pixel_x[4:0], pixel_y[9:5], breath_level[25:10], spin_cos[41:26],
  // spin_sin[57:42], zero pad[63:58]
  input  wire logic [63:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // alpha_byte[7:0], red_byte[15:8], green_byte[23:16], blue_byte[31:24]
  output logic [31:0]      m_axis_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);

  logic [23:0] accent_q, body_col_q;
  logic [NumStages-1:0] vld_q;
  logic en;

  // whole pipe advances unless the output word is stuck
  assign en = !vld_q[NumStages-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      accent_q <= AccentReset;
      body_col_q <= BodyReset;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid_i};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgAccent: accent_q <= cfg_data_i;
          CfgBody:   body_col_q <= cfg_data_i;
          default:   ;
        endcase
      end
    end
  end

  // stage registers
  logic signed [21:0] uc1_q, vs1_q, us1_q, vc1_q;
  logic [10:0]        r2_1_q;
  logic [15:0]        br_q [1:9];
  logic [21:0]        ax2_q, ay2_q, ax3_q;
  logic [22:0]        ds2_q, ds3_q;
  sq_t                sq2_q, sq3_q, sq4_q;
  logic [35:0]        hy3_q;
  logic [15:0]        body_q [4:12];
  logic [15:0]        dia_q [4:14];
  logic [15:0]        ring4_q;
  logic [31:0]        rg5_q;
  logic [12:0]        dq5_q;
  logic [15:0]        ring_q [6:13];
  logic               on_q [6:10];
  logic [10:0]        num6_q;
  logic [36:0]        pm6_q;
  logic [14:0]        t7_q;
  logic [29:0]        tt8_q;
  logic [30:0]        g9_q;
  logic [31:0]        gb10_q;
  logic [15:0]        g11_q;
  acc_t               acc12_q, acc13_q, acc14_q, acc15_q;
  logic [31:0]        out_q;

  // next values
  logic signed [21:0] uc1_d, vs1_d, us1_d, vc1_d;
  logic [10:0]        r2_1_d;
  logic [21:0]        ax2_d, ay2_d;
  logic [22:0]        ds2_d;
  sq_t                sq2_d, sq3_d, sq4_d, sq5;
  logic [35:0]        hy3_d;
  logic [15:0]        body4_d, dia4_d, ring4_d;
  logic [12:0]        dq5_d;
  logic [10:0]        num6_d;
  logic               on6_d;
  logic [36:0]        pm6_d;
  logic [14:0]        t7_d;
  logic [15:0]        g11_d;
  logic [31:0]        out_d;

  logic signed [5:0]  u2, v2;
  logic signed [15:0] cs, sn;
  logic signed [11:0] u2w, v2w, r2s;
  logic signed [22:0] rx, ry, dxs, dys;
  logic [21:0]        adx, ady;
  logic [22:0]        hsum, hh;
  logic signed [25:0] hd, hda;
  logic [14:0]        q7;
  logic [24:0]        rem7;
  logic [23:0]        ap;

  always_comb begin
    // stage 1: centered half-pixel coordinates and rotation products
    u2 = {~s_axis_tdata_i[4], s_axis_tdata_i[3:0], 1'b1};
    v2 = {~s_axis_tdata_i[9], s_axis_tdata_i[8:5], 1'b1};
    cs = s_axis_tdata_i[41:26];
    sn = s_axis_tdata_i[57:42];
    uc1_d = 22'(u2) * 22'(cs);
    vs1_d = 22'(v2) * 22'(sn);
    us1_d = 22'(u2) * 22'(sn);
    vc1_d = 22'(v2) * 22'(cs);
    u2w = 12'(u2);
    v2w = 12'(v2);
    r2s = u2w * u2w + v2w * v2w;
    r2_1_d = r2s[10:0];

    // stage 2: rotated magnitudes, first root digits
    rx = 23'(uc1_q) - 23'(vs1_q);
    ry = 23'(us1_q) + 23'(vc1_q);
    dxs = 23'(uc1_q) + 23'(vs1_q);
    dys = 23'(vc1_q) - 23'(us1_q);
    ax2_d = rx[22] ? 22'(-rx) : rx[21:0];
    ay2_d = ry[22] ? 22'(-ry) : ry[21:0];
    adx = dxs[22] ? 22'(-dxs) : dxs[21:0];
    ady = dys[22] ? 22'(-dys) : dys[21:0];
    ds2_d = 23'(adx) + 23'(ady);
    sq2_d.n = {r2_1_q, 14'd0};
    sq2_d.root = '0;
    for (int k = 0; k < 4; k++) begin
      sq2_d = sqrt_step(sq2_d, k);
    end

    // stage 3: hexagon slope term
    hy3_d = 36'(ay2_q) * 36'(HexKQ14);
    sq3_d = sq2_q;
    for (int k = 4; k < 7; k++) begin
      sq3_d = sqrt_step(sq3_d, k);
    end

    // stage 4: hexagon distance, body, ring and diamond coverage
    hsum = 23'(ax3_q >> 1) + 23'(hy3_q[35:14]);
    hh = (hsum > 23'(ax3_q)) ? hsum : 23'(ax3_q);
    body4_d = clamp_q15(BodyEdge - $signed(26'(hh)));
    hd = $signed(26'(hh)) - RingMid;
    hda = hd[25] ? -hd : hd;
    ring4_d = clamp_q15(OneQ15S - hda);
    dia4_d = clamp_q15(DiamondEdge - $signed(26'(ds3_q)));
    sq4_d = sq3_q;
    for (int k = 7; k < 10; k++) begin
      sq4_d = sqrt_step(sq4_d, k);
    end

    // stage 5: last root digits give the glow radius
    sq5 = sq4_q;
    for (int k = 10; k < 13; k++) begin
      sq5 = sqrt_step(sq5, k);
    end
    dq5_d = sq5.root[12:0];

    // stage 6: glow ramp numerator times reciprocal of the span
    on6_d = dq5_q < GlowOutQ8;
    num6_d = (on6_d && dq5_q >= GlowInQ8) ? 11'(dq5_q - GlowInQ8) : 11'd0;
    pm6_d = 37'(num6_d) * 37'(GlowRecip);

    // stage 7: quotient estimate is low by at most one
    q7 = pm6_q[35:21];
    rem7 = {num6_q, 14'd0} - 25'(25'(q7) * GlowSpanHalf);
    t7_d = (rem7 >= GlowSpanHalf) ? q7 + 15'd1 : q7;

    // stage 11: glow alpha, zero outside the outer radius
    g11_d = on_q[10] ? sat_q15(gb10_q[31:15]) : 16'd0;

    // stage 16: output bytes
    ap = 24'(acc15_q.a) * 24'd255;
    out_d[7:0] = (ap[23:15] > 9'd255) ? 8'd255 : ap[22:15];
    out_d[15:8] = acc15_q.r[22:15];
    out_d[23:16] = acc15_q.g[22:15];
    out_d[31:24] = acc15_q.b[22:15];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uc1_q <= uc1_d;
      vs1_q <= vs1_d;
      us1_q <= us1_d;
      vc1_q <= vc1_d;
      r2_1_q <= r2_1_d;
      br_q[1] <= s_axis_tdata_i[25:10];
      for (int i = 2; i <= 9; i++) begin
        br_q[i] <= br_q[i-1];
      end
      ax2_q <= ax2_d;
      ay2_q <= ay2_d;
      ds2_q <= ds2_d;
      sq2_q <= sq2_d;
      ax3_q <= ax2_q;
      ds3_q <= ds2_q;
      hy3_q <= hy3_d;
      sq3_q <= sq3_d;
      body_q[4] <= body4_d;
      dia_q[4] <= dia4_d;
      ring4_q <= ring4_d;
      sq4_q <= sq4_d;
      for (int i = 5; i <= 12; i++) begin
        body_q[i] <= body_q[i-1];
      end
      for (int i = 5; i <= 14; i++) begin
        dia_q[i] <= dia_q[i-1];
      end
      rg5_q <= 32'(ring4_q) * 32'(br_q[4]);
      dq5_q <= dq5_d;
      ring_q[6] <= sat_q15(rg5_q[31:15]);
      for (int i = 7; i <= 13; i++) begin
        ring_q[i] <= ring_q[i-1];
      end
      on_q[6] <= on6_d;
      for (int i = 7; i <= 10; i++) begin
        on_q[i] <= on_q[i-1];
      end
      num6_q <= num6_d;
      pm6_q <= pm6_d;
      t7_q <= t7_d;
      tt8_q <= 30'(t7_q) * 30'(t7_q);
      g9_q <= 31'(OneQ15 - 17'(tt8_q[29:15])) * 31'(GlowPeakQ15);
      gb10_q <= 32'(g9_q[30:15]) * 32'(br_q[9]);
      g11_q <= g11_d;
      acc12_q <= blend('0, accent_q, g11_q);
      acc13_q <= blend(acc12_q, body_col_q, body_q[12]);
      acc14_q <= blend(acc13_q, accent_q, ring_q[13]);
      acc15_q <= blend(acc14_q, accent_q, dia_q[14]);
      out_q <= out_d;
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule
`default_nettype wire
